### hw/rtl/psfl_pkg.sv
// ---------------------------------------------------------------------------
// psfl_pkg: shared types and constants of the per-source flood limiter
// Holds the word formats, register indexes and the front-to-back command.
// ---------------------------------------------------------------------------
package psfl_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegScoreShort   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegScoreLong    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTimeoutScore = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTimeoutDef   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBackoffReset = 3'd4;

  typedef enum logic {
    ActMessage = 1'b0,
    ActTick    = 1'b1
  } action_e;

  typedef struct packed {
    logic        action;
    logic [31:0] source_addr;
    logic [9:0]  msg_length;
  } in_word_t;

  typedef struct packed {
    logic        dropped;
    logic [15:0] seconds_left;
    logic        table_full;
  } out_word_t;

  typedef struct packed {
    logic [9:0]  score_short;
    logic [9:0]  score_long;
    logic [15:0] timeout_score;
    logic [15:0] timeout_default;
    logic [15:0] backoff_reset;
  } cfg_t;

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdHit   = 2'd1,
    CmdAlloc = 2'd2,
    CmdFull  = 2'd3
  } cmd_e;

endpackage

### hw/rtl/psfl_front.sv
// ---------------------------------------------------------------------------
// psfl_front: lookup and score stage
// Matches the source against the table, picks a free entry, computes the
// message score and passes a command word to the back end.
// ---------------------------------------------------------------------------
module psfl_front #(
  parameter int unsigned Entries   = 16,
  parameter int unsigned MaxMsgLen = 128,
  parameter int unsigned IdxW      = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  psfl_pkg::in_word_t     in_word_i,
  input  psfl_pkg::cfg_t         cfg_i,
  input  logic [Entries-1:0]     valid_i,
  input  logic [Entries-1:0][31:0] addr_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output psfl_pkg::cmd_e         cmd_o,
  output logic [IdxW-1:0]        cmd_idx_o,
  output logic [31:0]            cmd_addr_o,
  output logic [15:0]            cmd_score_o
);

  // divide the 21-bit product by MaxMsgLen+1 through a reciprocal multiply;
  // the rounded-up reciprocal with this shift is exact for every product
  localparam int unsigned DivD = MaxMsgLen + 1;
  localparam int unsigned DivS = 21 + $clog2(DivD);
  localparam logic [22:0] DivM =
    23'(((64'd1 << DivS) + 64'(DivD) - 64'd1) / 64'(DivD));

  logic                 busy_q, busy_d;
  psfl_pkg::in_word_t   word_q;
  logic [9:0]           len_c;
  logic [10:0]          slope_c;
  logic [20:0]          prod_q;
  logic                 prod_ok_q;
  logic                 hit_c, free_c;
  logic [IdxW-1:0]      hit_idx_c, free_idx_c;

  // hold a word while the product registers and until the back end takes it
  assign in_ready_o = !busy_q;
  assign busy_d     = busy_q ? !(cmd_ready_i) : in_valid_i;

  always_comb begin
    len_c = (in_word_i.msg_length > 10'(MaxMsgLen)) ? 10'(MaxMsgLen)
                                                    : in_word_i.msg_length;
    slope_c = {1'b0, cfg_i.score_long} + 11'd1 - {1'b0, cfg_i.score_short};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      word_q    <= in_word_i;
      prod_q    <= len_c * slope_c;
      prod_ok_q <= ({1'b0, cfg_i.score_long} + 11'd1) > {1'b0, cfg_i.score_short};
    end
  end

  always_comb begin
    hit_c = 1'b0;
    free_c = 1'b0;
    hit_idx_c = '0;
    free_idx_c = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (valid_i[i] && addr_i[i] == word_q.source_addr) begin
        hit_c = 1'b1;
        hit_idx_c = IdxW'(i);
      end
      if (!valid_i[i]) begin
        free_c = 1'b1;
        free_idx_c = IdxW'(i);
      end
    end
  end

  always_comb begin
    logic [16:0] sc;
    logic [43:0] qp;
    qp = 44'(prod_q) * 44'(DivM);
    sc = {7'd0, cfg_i.score_short};
    if (prod_ok_q) begin
      sc = sc + 17'(qp >> DivS);
    end
    cmd_score_o = sc[16] ? 16'hFFFF : sc[15:0];
    cmd_valid_o = busy_q;
    cmd_addr_o  = word_q.source_addr;
    cmd_idx_o   = hit_c ? hit_idx_c : free_idx_c;
    if (word_q.action == psfl_pkg::ActTick) begin
      cmd_o = psfl_pkg::CmdTick;
    end else if (hit_c) begin
      cmd_o = psfl_pkg::CmdHit;
    end else if (free_c) begin
      cmd_o = psfl_pkg::CmdAlloc;
    end else begin
      cmd_o = psfl_pkg::CmdFull;
    end
  end

endmodule

### hw/rtl/psfl_back.sv
// ---------------------------------------------------------------------------
// psfl_back: entry table and update stage
// Applies a command to the entry cells and writes the result word into a
// two-deep output queue.
// ---------------------------------------------------------------------------
module psfl_back #(
  parameter int unsigned Entries = 16,
  parameter int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  output logic                     cmd_ready_o,
  input  psfl_pkg::cmd_e           cmd_i,
  input  logic [IdxW-1:0]          cmd_idx_i,
  input  logic [31:0]              cmd_addr_i,
  input  logic [15:0]              cmd_score_i,
  input  psfl_pkg::cfg_t           cfg_i,
  output logic [Entries-1:0]       valid_o,
  output logic [Entries-1:0][31:0] addr_o,
  output logic                     empty_o,
  input  logic                     pop_i,
  output psfl_pkg::out_word_t      out_word_o
);

  logic [Entries-1:0]       valid_q;
  logic [Entries-1:0][31:0] addr_q;
  logic [Entries-1:0][15:0] score_q, tmo_q, next_q, boc_q;
  psfl_pkg::out_word_t      fifo_q [2];
  logic                     rd_q, wr_q;
  logic [1:0]               cnt_q;
  logic                     take_c;
  psfl_pkg::out_word_t      res_c;
  logic [15:0]              s_c, t_c, n_c, b_c;
  logic [16:0]              sum_c, dbl_c;

  assign valid_o     = valid_q;
  assign addr_o      = addr_q;
  assign cmd_ready_o = (cnt_q != 2'd2);
  assign take_c      = cmd_valid_i && cmd_ready_o;
  assign empty_o     = (cnt_q == 2'd0);
  assign out_word_o  = fifo_q[rd_q];

  // message update for the selected entry
  always_comb begin
    if (cmd_i == psfl_pkg::CmdAlloc) begin
      s_c = '0; t_c = '0; n_c = '0; b_c = '0;
    end else begin
      s_c = score_q[cmd_idx_i]; t_c = tmo_q[cmd_idx_i];
      n_c = next_q[cmd_idx_i];  b_c = boc_q[cmd_idx_i];
    end
    sum_c = {1'b0, s_c} + {1'b0, cmd_score_i};
    dbl_c = {n_c, 1'b0};
    if (t_c == 16'd0) begin
      s_c = sum_c[16] ? 16'hFFFF : sum_c[15:0];
      if (s_c >= cfg_i.timeout_score) begin
        if (n_c != 16'd0) begin
          n_c = dbl_c[16] ? 16'hFFFF : dbl_c[15:0];
        end else begin
          n_c = cfg_i.timeout_default;
        end
        t_c = n_c;
        b_c = cfg_i.backoff_reset;
      end
    end
    res_c = '0;
    if (cmd_i == psfl_pkg::CmdFull) begin
      res_c.table_full = 1'b1;
    end else if (cmd_i != psfl_pkg::CmdTick && t_c != 16'd0) begin
      res_c.dropped      = 1'b1;
      res_c.seconds_left = t_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_q    <= 1'b0;
      wr_q    <= 1'b0;
      cnt_q   <= 2'd0;
    end else begin
      if (take_c) begin
        wr_q <= !wr_q;
      end
      if (pop_i && !empty_o) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(take_c) - 2'(pop_i && !empty_o);
      if (take_c && cmd_i == psfl_pkg::CmdAlloc) begin
        valid_q[cmd_idx_i] <= 1'b1;
      end
      if (take_c && cmd_i == psfl_pkg::CmdTick) begin
        for (int i = 0; i < Entries; i++) begin
          if (valid_q[i] && score_q[i] <= 16'd1 && tmo_q[i] <= 16'd1 &&
              (boc_q[i] == 16'd0 || (tmo_q[i] == 16'd0 && boc_q[i] == 16'd1))) begin
            valid_q[i] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_c) begin
      fifo_q[wr_q] <= res_c;
      if (cmd_i == psfl_pkg::CmdTick) begin
        // decay every live cell in parallel
        for (int i = 0; i < Entries; i++) begin
          if (valid_q[i]) begin
            if (score_q[i] != 16'd0) score_q[i] <= score_q[i] - 16'd1;
            if (tmo_q[i] != 16'd0) begin
              tmo_q[i] <= tmo_q[i] - 16'd1;
              if (boc_q[i] == 16'd0) next_q[i] <= '0;
            end else if (boc_q[i] != 16'd0) begin
              boc_q[i] <= boc_q[i] - 16'd1;
              if (boc_q[i] == 16'd1) next_q[i] <= '0;
            end else begin
              next_q[i] <= '0;
            end
          end
        end
      end else if (cmd_i != psfl_pkg::CmdFull) begin
        addr_q[cmd_idx_i]  <= cmd_addr_i;
        score_q[cmd_idx_i] <= s_c;
        tmo_q[cmd_idx_i]   <= t_c;
        next_q[cmd_idx_i]  <= n_c;
        boc_q[cmd_idx_i]   <= b_c;
      end
    end
  end

endmodule

### hw/rtl/per_source_flood_limiter.sv
// ---------------------------------------------------------------------------
// per_source_flood_limiter: per-source message flood limiter
// Scores messages per IPv4 source and times out sources that flood.
// ---------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_word_i and raise push_i while full_o is low; a
//   word is either a message (scored against its source entry) or a tick
//   (one elapsed second that decays every entry and frees idle ones).
//   Output queue: while empty_o is low, out_word_o holds the oldest result;
//   raise pop_i to take it. Every input word yields exactly one result.
//   Pipeline: a pushed word is registered in the front, its result then
//   in the result queue. The front holds one word at a time for lookup
//   and score multiply and takes no new word until the back end takes it.
//   Stall: a two-deep result queue sits after the table update; when it
//   fills, the front holds its word and full_o stays high until pop_i.
//   Reset: all entries freed, registers at defaults, queues empty.
//   Config: write cfg_we_i/cfg_idx_i/cfg_data_i only while idle.
// ---------------------------------------------------------------------------
module per_source_flood_limiter #(
  parameter int unsigned Entries   = 16,
  parameter int unsigned MaxMsgLen = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  psfl_pkg::in_word_t                in_word_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output psfl_pkg::out_word_t               out_word_o,
  input  logic                              cfg_we_i,
  input  logic [psfl_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [psfl_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;

  psfl_pkg::cfg_t           cfg_q;
  logic                     in_ready;
  logic                     cmd_valid, cmd_ready;
  psfl_pkg::cmd_e           cmd;
  logic [IdxW-1:0]          cmd_idx;
  logic [31:0]              cmd_addr;
  logic [15:0]              cmd_score;
  logic [Entries-1:0]       valid;
  logic [Entries-1:0][31:0] addr;

  assign full_o = !in_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_short     <= 10'd5;
      cfg_q.score_long      <= 10'd10;
      cfg_q.timeout_score   <= 16'd10;
      cfg_q.timeout_default <= 16'd120;
      cfg_q.backoff_reset   <= 16'd1800;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psfl_pkg::RegScoreShort:   cfg_q.score_short     <= cfg_data_i[9:0];
        psfl_pkg::RegScoreLong:    cfg_q.score_long      <= cfg_data_i[9:0];
        psfl_pkg::RegTimeoutScore: cfg_q.timeout_score   <= cfg_data_i;
        psfl_pkg::RegTimeoutDef:   cfg_q.timeout_default <= cfg_data_i;
        psfl_pkg::RegBackoffReset: cfg_q.backoff_reset   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  psfl_front #(.Entries(Entries), .MaxMsgLen(MaxMsgLen), .IdxW(IdxW)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(push_i), .in_ready_o(in_ready), .in_word_i,
    .cfg_i(cfg_q), .valid_i(valid), .addr_i(addr),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd),
    .cmd_idx_o(cmd_idx), .cmd_addr_o(cmd_addr), .cmd_score_o(cmd_score)
  );

  psfl_back #(.Entries(Entries), .IdxW(IdxW)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .cmd_idx_i(cmd_idx), .cmd_addr_i(cmd_addr), .cmd_score_i(cmd_score),
    .cfg_i(cfg_q), .valid_o(valid), .addr_o(addr),
    .empty_o, .pop_i, .out_word_o
  );

endmodule
